// ===== src/gaw_pkg.sv =====
// Shared types and constants for the glyph advance width unit.
// Used by gaw_cfg_regs and glyph_advance_width_unit; no dependencies.
`default_nettype none

package gaw_pkg;

    // Input actions
    localparam logic [1:0] ACT_OFFSET  = 2'd0;
    localparam logic [1:0] ACT_SPACING = 2'd1;
    localparam logic [1:0] ACT_MEASURE = 2'd2;

    // Font kinds
    localparam logic [1:0] KIND_FIXED  = 2'd0;
    localparam logic [1:0] KIND_STRIKE = 2'd1;
    localparam logic [1:0] KIND_KERNED = 2'd2;

    // Register indexes (byte address = 4 * index)
    localparam int unsigned CFG_AW = 5;
    localparam logic [2:0] REG_FONT_KIND    = 3'd0;
    localparam logic [2:0] REG_FIRST_CODE   = 3'd1;
    localparam logic [2:0] REG_LAST_CODE    = 3'd2;
    localparam logic [2:0] REG_FIXED_WIDTH  = 3'd3;
    localparam logic [2:0] REG_FRAME_BYTES  = 3'd4;
    localparam logic [2:0] REG_RIGHT_OFFSET = 3'd5;

    localparam logic [7:0]  SPACE_CODE   = 8'd32;
    localparam logic [15:0] MISSING_WORD = 16'hFFFF;

    typedef struct packed {
        logic [1:0]  action;
        logic [8:0]  table_index;
        logic [15:0] entry_value;
        logic [7:0]  char_code;
        logic [7:0]  next_code;
        logic        last_of_string;
    } t_item;

    typedef struct packed {
        logic signed [15:0] advance;
        logic signed [23:0] total_width;
    } t_result;

    typedef struct packed {
        logic [1:0]        font_kind;
        logic [7:0]        first_code;
        logic [7:0]        last_code;
        logic [7:0]        fixed_width;
        logic [11:0]       frame_bytes;
        logic signed [7:0] right_offset;
    } t_cfg;

endpackage

`default_nettype wire

// ===== src/gaw_cfg_regs.sv =====
// APB register file holding the font configuration.
// Depends on gaw_pkg for the register indexes and the t_cfg struct.
`default_nettype none

module gaw_cfg_regs (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [gaw_pkg::CFG_AW-1:0]  paddr,
    input  wire logic [31:0]                 pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready,
    output gaw_pkg::t_cfg                    o_cfg
);

    gaw_pkg::t_cfg r_cfg;
    logic [2:0]    reg_idx;
    logic          wr_en;

    assign reg_idx = paddr[gaw_pkg::CFG_AW-1:2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.font_kind    <= gaw_pkg::KIND_FIXED;
            r_cfg.first_code   <= 8'd32;
            r_cfg.last_code    <= 8'd127;
            r_cfg.fixed_width  <= 8'd8;
            r_cfg.frame_bytes  <= 12'd0;
            r_cfg.right_offset <= 8'sd0;
        end else if (wr_en) begin
            case (reg_idx)
                gaw_pkg::REG_FONT_KIND:    r_cfg.font_kind    <= pwdata[1:0];
                gaw_pkg::REG_FIRST_CODE:   r_cfg.first_code   <= pwdata[7:0];
                gaw_pkg::REG_LAST_CODE:    r_cfg.last_code    <= pwdata[7:0];
                gaw_pkg::REG_FIXED_WIDTH:  r_cfg.fixed_width  <= pwdata[7:0];
                gaw_pkg::REG_FRAME_BYTES:  r_cfg.frame_bytes  <= pwdata[11:0];
                gaw_pkg::REG_RIGHT_OFFSET: r_cfg.right_offset <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            gaw_pkg::REG_FONT_KIND:    prdata = {30'd0, r_cfg.font_kind};
            gaw_pkg::REG_FIRST_CODE:   prdata = {24'd0, r_cfg.first_code};
            gaw_pkg::REG_LAST_CODE:    prdata = {24'd0, r_cfg.last_code};
            gaw_pkg::REG_FIXED_WIDTH:  prdata = {24'd0, r_cfg.fixed_width};
            gaw_pkg::REG_FRAME_BYTES:  prdata = {20'd0, r_cfg.frame_bytes};
            gaw_pkg::REG_RIGHT_OFFSET: prdata = {24'd0, r_cfg.right_offset};
            default:                   prdata = 32'd0;
        endcase
    end

endmodule

`default_nettype wire

// ===== src/glyph_advance_width_unit.sv =====
// Glyph advance width unit: measures raster-font text with optional kerning.
// Depends on gaw_pkg and gaw_cfg_regs.
`default_nettype none

// Usage
//   Items arrive on i_item and are taken at a rising edge with start high and
//   busy low. Offset and spacing loads write one table entry at that edge and
//   give no result; the next item may follow in the very next cycle.
//   A measure transaction reads two entries from each single-port table: the
//   glyph's own entries (end-of-font offset for a kerned font) at the accept
//   edge, then the next entries (offset after it, kern of the following glyph)
//   in the cycle after. busy is high for that one cycle only. The advance and
//   the saturated running total are computed in the finish state, registered
//   and shown on o_result with o_done high for exactly one cycle.
//   Throughput: one load every cycle while busy is low; a measure raises busy
//   for its second read, set by the two reads per table port. A new item may
//   be taken in the cycle in which the previous measure is being finished.
//   The receiver cannot stall: each o_done cycle is one result transaction.
//   Configuration lives on the APB port at byte address 4*index; write it
//   only while no measure is in flight.
//   Reset restores the default configuration and clears the running total.
//   The glyph tables are not cleared; load every entry a font uses first.
module glyph_advance_width_unit #(
    parameter int unsigned GLYPHS = 256
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        start,
    output logic                             busy,
    input  wire gaw_pkg::t_item              i_item,
    output logic                             o_done,
    output gaw_pkg::t_result                 o_result,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [gaw_pkg::CFG_AW-1:0]  paddr,
    input  wire logic [31:0]                 pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready
);

    localparam int unsigned SP_AW = $clog2(GLYPHS);
    localparam int unsigned OF_AW = $clog2(GLYPHS + 1);
    localparam logic signed [9:0] MAX_GLYPH = 10'(GLYPHS - 1);
    localparam logic signed [9:0] NUM_GLYPH = 10'(GLYPHS);
    localparam logic [8:0] IDX_GLYPHS = 9'(GLYPHS);

    // Sequencer states
    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SECOND = 2'd1;
    localparam logic [1:0] S_FINISH = 2'd2;

    gaw_pkg::t_cfg cfg;

    gaw_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // Clamp a character code to a glyph index: above the font becomes space,
    // below the font uses space's index, then pin to the table.
    function automatic logic [SP_AW-1:0] f_glyph(input logic [7:0] code,
                                                input logic [7:0] first,
                                                input logic [7:0] last);
        logic [7:0]        cc;
        logic signed [9:0] d;
        cc = (code > last) ? gaw_pkg::SPACE_CODE : code;
        d  = $signed({2'b00, cc}) - $signed({2'b00, first});
        if (d < 0)
            d = $signed({2'b00, gaw_pkg::SPACE_CODE}) - $signed({2'b00, first});
        if (d < 0)
            d = 10'sd0;
        if (d > MAX_GLYPH)
            d = MAX_GLYPH;
        return d[SP_AW-1:0];
    endfunction

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    logic [1:0] r_state, n_state;
    logic       accept, meas;

    assign busy   = (r_state == S_SECOND);
    assign accept = start && !busy;
    assign meas   = accept && (i_item.action == gaw_pkg::ACT_MEASURE);

    always_comb begin
        case (r_state)
            S_IDLE, S_FINISH: n_state = meas ? S_SECOND : S_IDLE;
            S_SECOND:         n_state = S_FINISH;
            default:          n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Indexes of the incoming measure transaction
    logic [SP_AW-1:0]  c_in, n_in;
    logic signed [9:0] t_raw;
    logic [OF_AW-1:0]  t_in;

    assign c_in  = f_glyph(i_item.char_code, cfg.first_code, cfg.last_code);
    assign n_in  = f_glyph(i_item.next_code, cfg.first_code, cfg.last_code);
    assign t_raw = $signed({2'b00, cfg.last_code}) - $signed({2'b00, cfg.first_code})
                   + 10'sd1;

    always_comb begin
        if (t_raw < 0)
            t_in = '0;
        else if (t_raw > NUM_GLYPH)
            t_in = OF_AW'(GLYPHS);
        else
            t_in = t_raw[OF_AW-1:0];
    end

    // Hold what the second read and the finish step need
    logic [SP_AW-1:0] r_c, r_n;
    logic             r_has_next, r_last;

    always_ff @(posedge i_clk) begin
        if (meas) begin
            r_c        <= c_in;
            r_n        <= n_in;
            r_has_next <= (i_item.next_code != 8'd0);
            r_last     <= i_item.last_of_string;
        end
    end

    // ------------------------------------------------------------------
    // Glyph tables: one port each, read data registered for the next cycle
    // ------------------------------------------------------------------
    logic [14:0] offset_mem [GLYPHS+1];
    logic [15:0] spacing_mem [GLYPHS];

    logic             off_we, sp_we, rd_en;
    logic [OF_AW-1:0] off_addr;
    logic [SP_AW-1:0] sp_addr;
    logic [14:0]      r_off_q, r_off_a;
    logic [15:0]      r_sp_q, r_sp_a;

    assign off_we = accept && (i_item.action == gaw_pkg::ACT_OFFSET)
                    && (i_item.table_index <= IDX_GLYPHS);
    assign sp_we  = accept && (i_item.action == gaw_pkg::ACT_SPACING)
                    && (i_item.table_index < IDX_GLYPHS);
    assign rd_en  = meas || (r_state == S_SECOND);

    // First read: own offset (strike) or end-of-font offset (kerned);
    // second read: the offset after the glyph. Writes take the same port.
    always_comb begin
        if (r_state == S_SECOND)
            off_addr = OF_AW'(r_c) + OF_AW'(1);
        else if (meas)
            off_addr = (cfg.font_kind == gaw_pkg::KIND_STRIKE) ? OF_AW'(c_in) : t_in;
        else
            off_addr = i_item.table_index[OF_AW-1:0];
    end

    always_comb begin
        if (r_state == S_SECOND)
            sp_addr = r_n;
        else if (meas)
            sp_addr = c_in;
        else
            sp_addr = i_item.table_index[SP_AW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (off_we)
            offset_mem[off_addr] <= i_item.entry_value[14:0];
        if (rd_en)
            r_off_q <= offset_mem[off_addr];
    end

    always_ff @(posedge i_clk) begin
        if (sp_we)
            spacing_mem[sp_addr] <= i_item.entry_value;
        if (rd_en)
            r_sp_q <= spacing_mem[sp_addr];
    end

    // Keep the first read while the second one lands
    always_ff @(posedge i_clk) begin
        if (r_state == S_SECOND) begin
            r_off_a <= r_off_q;
            r_sp_a  <= r_sp_q;
        end
    end

    // ------------------------------------------------------------------
    // Finish: advance and saturating running total
    // ------------------------------------------------------------------
    logic signed [16:0] adv;
    logic signed [16:0] kern_term;
    logic signed [24:0] sum_wide;
    logic signed [23:0] sum_sat;
    logic signed [23:0] r_total;

    always_comb begin
        kern_term = 17'sd0;
        if (r_has_next)
            kern_term = 17'($signed(r_sp_q[7:0])) + 17'(cfg.right_offset);
        case (cfg.font_kind)
            gaw_pkg::KIND_FIXED:
                adv = $signed({9'd0, cfg.fixed_width});
            gaw_pkg::KIND_STRIKE:
                adv = $signed({2'b00, r_off_q}) - $signed({2'b00, r_off_a});
            gaw_pkg::KIND_KERNED: begin
                if (r_sp_a == gaw_pkg::MISSING_WORD)
                    adv = $signed({2'b00, cfg.frame_bytes, 3'b000})
                          - $signed({2'b00, r_off_a});
                else
                    adv = 17'($signed(r_sp_a[15:8])) + kern_term;
            end
            default:
                adv = 17'sd0;
        endcase
    end

    assign sum_wide = 25'(r_total) + 25'(adv);

    always_comb begin
        case (sum_wide[24:23])
            2'b01:   sum_sat = 24'sh7FFFFF;
            2'b10:   sum_sat = 24'sh800000;
            default: sum_sat = sum_wide[23:0];
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total <= '0;
            o_done  <= 1'b0;
        end else begin
            o_done <= (r_state == S_FINISH);
            if (r_state == S_FINISH)
                r_total <= r_last ? 24'sd0 : sum_sat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_FINISH) begin
            o_result.advance     <= adv[15:0];
            o_result.total_width <= sum_sat;
        end
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_measure_enters_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        meas |=> (r_state == S_SECOND))
        else $error("measure transaction did not start its second read");

    a_done_follows_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FINISH) |=> o_done)
        else $error("finished measure produced no result");

    a_done_only_after_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(r_state == S_FINISH))
        else $error("result strobe without a finished measure");

    a_total_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FINISH && r_last) |=> (r_total == 24'sd0))
        else $error("running total not cleared at end of string");

endmodule

`default_nettype wire
